// ===== rtl/core/colormap_linear_light_interp_core_defines.svh =====
// Assertion macros shared by the colormap core checker.
// No dependencies; included by the checker file.
`ifndef COLORMAP_LINEAR_LIGHT_INTERP_CORE_DEFINES_SVH
`define COLORMAP_LINEAR_LIGHT_INTERP_CORE_DEFINES_SVH

// Clocked check, masked while reset is asserted
`define CLR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("colormap core check failed");

// Clocked check that also runs during reset
`define CLR_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("colormap core reset check failed");

`endif

// ===== rtl/core/clr_pkg.sv =====
// Package for the colormap core: sizes, codes, sideband type and the sRGB tables.
// No dependencies; imported by clr_if, clr_div, clr_enc and the core module.
package clr_pkg;

	localparam int PALETTE_DEPTH    = 256;
	localparam int ADDR_W           = $clog2(PALETTE_DEPTH);
	localparam int LINEAR_FRAC_BITS = 16;
	localparam int LIN_W            = LINEAR_FRAC_BITS + 1;
	localparam int BLEND_BITS       = 16;
	localparam int FRAC_W           = BLEND_BITS + 1;
	localparam int CODE_W           = 8;
	localparam int CODES            = 1 << CODE_W;
	localparam int SEG_W            = 8;
	localparam int QUO_W            = SEG_W + BLEND_BITS;
	localparam int DEN_W            = 33;
	localparam int PROD_W           = 41;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_MAP  = 1'b1
	} clr_mode_t;

	typedef enum logic [1:0] {
		CFG_PALETTE_SIZE = 2'd0,
		CFG_VALUE_MIN    = 2'd1,
		CFG_VALUE_MAX    = 2'd2
	} clr_cfg_t;

	// sideband that rides along the divider
	typedef struct packed {
		logic        map;
		logic        err;
		logic [7:0]  idx;
		logic [23:0] ecolor;
	} clr_sb_t;

	typedef logic [LIN_W-1:0] lin_tab_t [CODES];
	typedef logic [LIN_W-1:0] thr_tab_t [CODES-1];

	function automatic logic [63:0] pow5_q30(input logic [63:0] r);
		logic [63:0] p;
		p = r;
		for (int k = 0; k < 4; k++)
			p = (p * r) >> 30;
		return p;
	endfunction

	// sRGB decode at s = n/510 into linear light
	function automatic logic [LIN_W-1:0] decode_half(input int unsigned n);
		logic [63:0] nn, a, x, x2, lo, hi, mid, y;
		nn = 64'(n);
		if (nn * 64'd1000000 <= 64'd20629500)
			return LIN_W'((((nn * 64'd100) << LINEAR_FRAC_BITS) + 64'd329460) / 64'd658920);
		a  = 64'd1000 * nn + 64'd28050;
		x  = (a << 30) / 64'd538050;
		x2 = (x * x) >> 30;
		lo = 64'd0;
		hi = 64'd1 << 30;
		// fifth root by bisection
		for (int i = 0; i < 40; i++) begin
			if (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				if (pow5_q30(mid) <= x2)
					lo = mid;
				else
					hi = mid - 64'd1;
			end
		end
		y = (x2 * lo) >> 30;
		return LIN_W'((y + (64'd1 << (29 - LINEAR_FRAC_BITS))) >> (30 - LINEAR_FRAC_BITS));
	endfunction

	function automatic lin_tab_t build_lin();
		lin_tab_t t;
		for (int c = 0; c < CODES; c++)
			t[c] = decode_half(2 * c);
		return t;
	endfunction

	function automatic thr_tab_t build_thr();
		thr_tab_t t;
		for (int c = 0; c < CODES - 1; c++)
			t[c] = decode_half(2 * c + 1);
		return t;
	endfunction

	localparam lin_tab_t LIN_TAB = build_lin();
	localparam thr_tab_t THR_TAB = build_thr();

endpackage

// ===== rtl/core/clr_if.sv =====
// Stream interfaces for the colormap core: request beats in, color beats out.
// Depends on clr_pkg.
interface clr_in_if import clr_pkg::*;;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [ADDR_W-1:0]  entry_index;
	logic [23:0]        entry_color;
	logic signed [31:0] value;

	modport source(output valid, mode, entry_index, entry_color, value, input ready);
	modport sink(input valid, mode, entry_index, entry_color, value, output ready);
endinterface

interface clr_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] color;
	logic        range_error;

	modport source(output valid, color, range_error, input ready);
	modport sink(input valid, color, range_error, output ready);
endinterface

// ===== rtl/core/clr_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module clr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

// ===== rtl/core/clr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on clr_pkg.
module clr_div import clr_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [DEN_W-1:0] rem_in,
	input  logic [QUO_W-1:0] low_in,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);
	logic [DEN_W-1:0] rem_q [QUO_W];
	logic [QUO_W-1:0] w_q   [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		logic [DEN_W-1:0] r_in;
		logic [QUO_W-1:0] w_in;
		logic [DEN_W:0]   r_ext;
		logic             ge;

		if (i == 0) begin : g_first
			assign r_in = rem_in;
			assign w_in = low_in;
		end else begin : g_next
			assign r_in = rem_q[i-1];
			assign w_in = w_q[i-1];
		end

		// shift in one dividend bit, subtract when it fits
		assign r_ext = {r_in, w_in[QUO_W-1]};
		assign ge    = r_ext >= {1'b0, den};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? DEN_W'(r_ext - {1'b0, den}) : DEN_W'(r_ext);
				w_q[i]   <= {w_in[QUO_W-2:0], ge};
			end
		end
	end

	assign quo = w_q[QUO_W-1];
endmodule

// ===== rtl/core/clr_enc.sv =====
// sRGB encoder: pipelined binary search over the threshold table, one bit per stage.
// Depends on clr_pkg.
module clr_enc import clr_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [LIN_W-1:0]  lin,
	output logic [CODE_W-1:0] code
);
	logic [LIN_W-1:0]  lin_q  [CODE_W];
	logic [CODE_W-1:0] code_q [CODE_W];

	for (genvar i = 0; i < CODE_W; i++) begin : g_step
		logic [LIN_W-1:0]  lin_in;
		logic [CODE_W-1:0] code_in;
		logic [CODE_W-1:0] cand;

		if (i == 0) begin : g_first
			assign lin_in  = lin;
			assign code_in = '0;
		end else begin : g_next
			assign lin_in  = lin_q[i-1];
			assign code_in = code_q[i-1];
		end

		// try setting the next code bit
		assign cand = code_in | (CODE_W'(1) << (CODE_W - 1 - i));

		always_ff @(posedge clk) begin
			if (en) begin
				lin_q[i]  <= lin_in;
				code_q[i] <= (lin_in >= THR_TAB[cand - CODE_W'(1)]) ? cand : code_in;
			end
		end
	end

	assign code = code_q[CODE_W-1];
endmodule

// ===== rtl/core/colormap_linear_light_interp_core.sv =====
// Colormap core: maps a Q16.16 scalar to 0xRRGGBB through a palette, blending in
// linear light. One beat is accepted per clock when the pipeline advances; a map
// beat's color is built by the pipelined divider that finds segment and fraction
// and the sRGB encoder search. Load beats write the palette in the same
// stage where map beats read both neighboring entries from a two-read-port RAM, so
// beats act in arrival order. The whole pipeline holds while a result waits at the
// output register; input ready is the pipeline advance. Palette entries are
// undefined until loaded. Depends on clr_pkg, clr_if, clr_div, clr_enc, clr_ram.
module colormap_linear_light_interp_core import clr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	clr_in_if.sink      in_ch,
	clr_out_if.source   out_ch
);
	localparam int ENC_STAGES = CODE_W;

	// configuration
	logic [8:0]         palette_size_q;
	logic signed [31:0] value_min_q;
	logic signed [31:0] value_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= 9'd2;
			value_min_q    <= 32'sd0;
			value_max_q    <= 32'sd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PALETTE_SIZE: palette_size_q <= cfg_data[8:0];
				CFG_VALUE_MIN:    value_min_q    <= cfg_data;
				CFG_VALUE_MAX:    value_max_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	// clamped palette size and range width
	logic [8:0]       nsz;
	logic [SEG_W-1:0] nsz_m1, nsz_m2;
	logic [DEN_W-1:0] den;

	always_comb begin
		if (palette_size_q < 9'd2)
			nsz = 9'd2;
		else if (palette_size_q > 9'(PALETTE_DEPTH))
			nsz = 9'(PALETTE_DEPTH);
		else
			nsz = palette_size_q;
	end

	assign nsz_m1 = SEG_W'(nsz - 9'd1);
	assign nsz_m2 = SEG_W'(nsz - 9'd2);
	assign den    = {value_max_q[31], value_max_q} - {value_min_q[31], value_min_q};

	logic en;
	logic out_valid_q;

	assign en          = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en;

	// stage 1: range check and offset
	logic             valid_s1;
	clr_sb_t          sb_s1;
	logic [DEN_W-1:0] num_s1;
	logic             err_c;

	assign err_c = (in_ch.value < value_min_q) || (in_ch.value > value_max_q)
		|| (value_min_q == value_max_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1.map    <= (in_ch.mode == MODE_MAP);
			sb_s1.err    <= err_c;
			sb_s1.idx    <= in_ch.entry_index;
			sb_s1.ecolor <= in_ch.entry_color;
			num_s1       <= {in_ch.value[31], in_ch.value} - {value_min_q[31], value_min_q};
		end
	end

	// stage 2: scale by segment count
	logic              valid_s2;
	clr_sb_t           sb_s2;
	logic [PROD_W-1:0] q_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s2 <= sb_s1;
			q_s2  <= PROD_W'(num_s1) * PROD_W'(nsz_m1);
		end
	end

	// divider and matching sideband delay line
	logic [QUO_W-1:0] quo;
	logic             vld_d [QUO_W];
	clr_sb_t          sb_d  [QUO_W];

	clr_div u_div (
		.clk    (clk),
		.en     (en),
		.rem_in (q_s2[PROD_W-1:SEG_W]),
		.low_in ({q_s2[SEG_W-1:0], BLEND_BITS'(0)}),
		.den    (den),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUO_W; i++)
				vld_d[i] <= 1'b0;
		end else if (en) begin
			vld_d[0] <= valid_s2;
			for (int i = 1; i < QUO_W; i++)
				vld_d[i] <= vld_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_d[0] <= sb_s2;
			for (int i = 1; i < QUO_W; i++)
				sb_d[i] <= sb_d[i-1];
		end
	end

	// segment fixup: top of range lands on last segment with full fraction
	logic              valid_sf;
	clr_sb_t           sb_sf;
	logic [SEG_W-1:0]  seg_sf;
	logic [FRAC_W-1:0] frac_sf;
	logic [SEG_W-1:0]  seg_raw;

	assign seg_raw = quo[QUO_W-1:BLEND_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_sf <= 1'b0;
		else if (en)
			valid_sf <= vld_d[QUO_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_sf <= sb_d[QUO_W-1];
			if (seg_raw > nsz_m2) begin
				seg_sf  <= nsz_m2;
				frac_sf <= FRAC_W'(1) << BLEND_BITS;
			end else begin
				seg_sf  <= seg_raw;
				frac_sf <= {1'b0, quo[BLEND_BITS-1:0]};
			end
		end
	end

	// palette: loads write, maps read both neighbors
	logic [23:0] pal_lo, pal_hi;

	clr_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_pal (
		.clk     (clk),
		.we      (en && valid_sf && !sb_sf.map),
		.waddr   (sb_sf.idx),
		.wdata   (sb_sf.ecolor),
		.re      (en),
		.raddr_a (ADDR_W'(seg_sf)),
		.raddr_b (ADDR_W'(seg_sf + SEG_W'(1))),
		.rdata_a (pal_lo),
		.rdata_b (pal_hi)
	);

	logic              valid_sm, map_sm, err_sm;
	logic [FRAC_W-1:0] frac_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_sm <= 1'b0;
		else if (en)
			valid_sm <= valid_sf;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			map_sm  <= sb_sf.map;
			err_sm  <= sb_sf.err;
			frac_sm <= frac_sf;
		end
	end

	// decode to linear light
	logic              valid_sl, map_sl, err_sl;
	logic [FRAC_W-1:0] frac_sl;
	logic [LIN_W-1:0]  lo_sl [3];
	logic [LIN_W-1:0]  hi_sl [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_sl <= 1'b0;
		else if (en)
			valid_sl <= valid_sm;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			map_sl  <= map_sm;
			err_sl  <= err_sm;
			frac_sl <= frac_sm;
			for (int c = 0; c < 3; c++) begin
				lo_sl[c] <= LIN_TAB[pal_lo[c*8 +: 8]];
				hi_sl[c] <= LIN_TAB[pal_hi[c*8 +: 8]];
			end
		end
	end

	// blend, step 1: magnitude times fraction
	logic                    valid_sb1, map_sb1, err_sb1;
	logic                    up_sb1  [3];
	logic [LIN_W-1:0]        lo_sb1  [3];
	logic [LIN_W+FRAC_W-1:0] prod_sb1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_sb1 <= 1'b0;
		else if (en)
			valid_sb1 <= valid_sl;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			map_sb1 <= map_sl;
			err_sb1 <= err_sl;
			for (int c = 0; c < 3; c++) begin
				up_sb1[c]   <= hi_sl[c] >= lo_sl[c];
				lo_sb1[c]   <= lo_sl[c];
				prod_sb1[c] <= (LIN_W+FRAC_W)'(hi_sl[c] >= lo_sl[c]
					? hi_sl[c] - lo_sl[c] : lo_sl[c] - hi_sl[c]) * (LIN_W+FRAC_W)'(frac_sl);
			end
		end
	end

	// blend, step 2: round half up and apply sign
	logic             valid_sb2, map_sb2, err_sb2;
	logic [LIN_W-1:0] lin_sb2 [3];
	logic [LIN_W-1:0] rnd     [3];

	always_comb begin
		for (int c = 0; c < 3; c++)
			rnd[c] = LIN_W'((prod_sb1[c] + (LIN_W+FRAC_W)'(1 << (BLEND_BITS - 1))) >> BLEND_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_sb2 <= 1'b0;
		else if (en)
			valid_sb2 <= valid_sb1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			map_sb2 <= map_sb1;
			err_sb2 <= err_sb1;
			for (int c = 0; c < 3; c++)
				lin_sb2[c] <= up_sb1[c] ? lo_sb1[c] + rnd[c] : lo_sb1[c] - rnd[c];
		end
	end

	// encode back to sRGB codes
	logic [CODE_W-1:0] code [3];

	for (genvar c = 0; c < 3; c++) begin : g_enc
		clr_enc u_enc (
			.clk  (clk),
			.en   (en),
			.lin  (lin_sb2[c]),
			.code (code[c])
		);
	end

	logic vld_e [ENC_STAGES];
	logic map_e [ENC_STAGES];
	logic err_e [ENC_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENC_STAGES; i++)
				vld_e[i] <= 1'b0;
		end else if (en) begin
			vld_e[0] <= valid_sb2;
			for (int i = 1; i < ENC_STAGES; i++)
				vld_e[i] <= vld_e[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			map_e[0] <= map_sb2;
			err_e[0] <= err_sb2;
			for (int i = 1; i < ENC_STAGES; i++) begin
				map_e[i] <= map_e[i-1];
				err_e[i] <= err_e[i-1];
			end
		end
	end

	// output register
	logic [23:0] color_q;
	logic        range_error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= vld_e[ENC_STAGES-1] && map_e[ENC_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			range_error_q <= err_e[ENC_STAGES-1];
			color_q       <= err_e[ENC_STAGES-1] ? 24'd0 : {code[2], code[1], code[0]};
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.color       = color_q;
	assign out_ch.range_error = range_error_q;
endmodule

// ===== rtl/core/clr_chk.sv =====
// Port-level checker for the colormap core, bound to the top level.
// Depends on colormap_linear_light_interp_core_defines.svh.
`include "colormap_linear_light_interp_core_defines.svh"

module clr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] color,
	input logic        range_error
);
	// a held result keeps its payload
	`CLR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(color) && $stable(range_error))
	// an error beat carries black
	`CLR_ASSERT(a_err_black, out_valid && range_error |-> color == 24'd0)
	// with the output free the block takes a beat
	`CLR_ASSERT(a_ready_free, !out_valid || out_ready |-> in_ready)
	// no result while reset is held
	`CLR_ASSERT_RST(a_rst_quiet, !arst_n |-> !out_valid)
endmodule

bind colormap_linear_light_interp_core clr_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.color       (out_ch.color),
	.range_error (out_ch.range_error)
);
